// ----- design/bal_pkg.sv -----
// Shared types and constants for the buddy allocator.
// Node state codes, result status codes and default geometry.
// No dependencies.
package bal_pkg;

  localparam int DEF_MIN_BLOCK_BYTES = 8;
  localparam int DEF_MAX_BLOCK_BYTES = 2048;
  localparam int DEF_LEVELS          = 9;

  localparam int SIZE_W = 16;
  localparam int OFF_W  = 11;
  localparam int LVL_W  = 4;

  typedef enum logic [1:0] {
    ND_ABSENT = 2'd0,
    ND_FREE   = 2'd1,
    ND_SPLIT  = 2'd2,
    ND_ALLOC  = 2'd3
  } node_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

endpackage

// ----- design/bal_mem.sv -----
// Node state memory of the buddy tree, heap ordered.
// One write port, one read port with registered read data.
// Depends on bal_pkg.
module bal_mem
  import bal_pkg::*;
#(
  parameter int ADDR_W = 9,
  parameter int DEPTH  = 511
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  node_t             wdata,
  input  logic [ADDR_W-1:0] raddr,
  output node_t             rdata
);

  node_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/buddy_allocator_core.sv -----
// Buddy allocator core: request sequencer over the node state memory.
// Allocate: scans one node per cycle through the memory read port (exact size level, then all
// larger levels); a request that is too large is refused without a scan.
// Free: visits nodes from the root down to the allocated block, then merges with free buddies.
// One request in flight; the output register frees the input side once loaded.
// Reset (sync, active high) starts a clear pass over all 2^LEVELS-1 nodes; stall stays high.
module buddy_allocator_core
  import bal_pkg::*;
#(
  parameter int MIN_BLOCK_BYTES = DEF_MIN_BLOCK_BYTES,
  parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
  parameter int LEVELS          = DEF_LEVELS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  logic [SIZE_W-1:0] req_size,
  input  logic [OFF_W-1:0]  free_offset,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [OFF_W-1:0]  block_offset,
  output logic [LVL_W-1:0]  size_class
);

  localparam int NODES   = (1 << LEVELS) - 1;
  localparam int IDX_W   = LEVELS;
  localparam int DW      = $clog2(LEVELS + 1);
  localparam int LOG_MAX = $clog2(MAX_BLOCK_BYTES);
  localparam int OW      = (LOG_MAX + 1 > OFF_W) ? LOG_MAX + 1 : OFF_W + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXACT, S_LARGE, S_SPLIT, S_SPLIT_R,
    S_FR_RD, S_FR_CHK, S_MG_RD, S_MG_CHK, S_MG_W2, S_MG_W3, S_FIN
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  clr_cnt;
  logic [OW-1:0]     req_off;
  logic [DW-1:0]     lvl;
  logic [DW-1:0]     want_d;
  logic [IDX_W-1:0]  cnt;
  logic [IDX_W-1:0]  lim;
  logic              pv;
  logic [IDX_W-1:0]  pidx;
  logic              found;
  logic [OW-1:0]     best_off;
  logic [IDX_W-1:0]  best;
  logic [DW-1:0]     best_d;
  logic [IDX_W-1:0]  cur;
  logic [DW-1:0]     cur_d;
  logic [OW-1:0]     base;
  status_t           res_status;
  logic [OFF_W-1:0]  res_off;
  logic [LVL_W-1:0]  res_lvl;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  node_t             mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  node_t             rdata;

  logic              accept;
  logic              rd_free;
  logic [IDX_W-1:0]  sib;
  logic [IDX_W-1:0]  parent;
  logic [IDX_W-1:0]  left_c;
  logic [IDX_W-1:0]  right_c;
  logic [DW-1:0]     in_lvl;
  logic [DW-1:0]     in_want;
  logic [DW-1:0]     pdepth;
  logic [OW-1:0]     poff;
  logic [OW-1:0]     half;

  function automatic logic [DW-1:0] size_level(input logic [SIZE_W-1:0] req);
    logic [DW-1:0] l;
    l = DW'(LEVELS - 1);
    for (int k = LEVELS - 2; k >= 0; k--) begin
      if (32'(req) <= (32'(MIN_BLOCK_BYTES) << k)) l = DW'(k);
    end
    return l;
  endfunction

  function automatic logic [IDX_W-1:0] first_of(input logic [DW-1:0] d);
    logic [IDX_W:0] t;
    t = ((IDX_W+1)'(1) << d) - (IDX_W+1)'(1);
    return t[IDX_W-1:0];
  endfunction

  function automatic logic [DW-1:0] depth_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] t;
    logic [DW-1:0]  d;
    t = (IDX_W+1)'(idx) + (IDX_W+1)'(1);
    d = '0;
    for (int k = 1; k <= IDX_W; k++) begin
      if ((t >> k) != '0) d = DW'(k);
    end
    return d;
  endfunction

  function automatic logic [OW-1:0] off_of(input logic [IDX_W-1:0] idx,
                                           input logic [DW-1:0] d);
    logic [OW-1:0] t;
    t = OW'(idx) + OW'(1) - (OW'(1) << d);
    return t << (OW'(LOG_MAX) - OW'(d));
  endfunction

  bal_mem #(
    .ADDR_W(IDX_W),
    .DEPTH (NODES)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign rd_free  = (rdata == ND_FREE);
  assign sib      = cur[0] ? cur + IDX_W'(1) : cur - IDX_W'(1);
  assign parent   = (cur - IDX_W'(1)) >> 1;
  assign left_c   = (cur << 1) + IDX_W'(1);
  assign right_c  = (cur << 1) + IDX_W'(2);
  assign in_lvl   = size_level(req_size);
  assign in_want  = DW'(LEVELS - 1) - in_lvl;
  assign pdepth   = depth_of(pidx);
  assign poff     = off_of(pidx, pdepth);
  assign half     = OW'(1) << (OW'(LOG_MAX) - OW'(cur_d) - OW'(1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = ND_FREE;
    mem_raddr = cnt;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = (clr_cnt == '0) ? ND_FREE : ND_ABSENT;
      end
      S_EXACT: begin
        mem_waddr = pidx;
        mem_wdata = ND_ALLOC;
        mem_we    = pv && rd_free;
      end
      S_SPLIT: begin
        mem_we    = 1'b1;
        mem_wdata = (cur_d == want_d) ? ND_ALLOC : ND_SPLIT;
      end
      S_SPLIT_R: begin
        mem_we    = 1'b1;
        mem_waddr = right_c;
      end
      S_FR_RD:  mem_raddr = cur;
      S_FR_CHK: mem_we = (rdata == ND_ALLOC) && (base == req_off);
      S_MG_RD:  mem_raddr = sib;
      S_MG_CHK: begin
        mem_we    = rd_free;
        mem_wdata = ND_ABSENT;
      end
      S_MG_W2: begin
        mem_we    = 1'b1;
        mem_waddr = sib;
        mem_wdata = ND_ABSENT;
      end
      S_MG_W3: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      pv        <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + IDX_W'(1);
          if (clr_cnt == IDX_W'(NODES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            req_off <= OW'(free_offset);
            res_off <= '0;
            res_lvl <= '0;
            pv      <= 1'b0;
            found   <= 1'b0;
            if (!req_type) begin
              if (32'(req_size) > 32'(MAX_BLOCK_BYTES)) begin
                res_status <= ST_TOO_LARGE;
                state      <= S_FIN;
              end else begin
                lvl    <= in_lvl;
                want_d <= in_want;
                cnt    <= first_of(in_want);
                lim    <= first_of(in_want + DW'(1));
                state  <= S_EXACT;
              end
            end else begin
              cur   <= '0;
              cur_d <= '0;
              base  <= '0;
              if (OW'(free_offset) >= OW'(MAX_BLOCK_BYTES)) begin
                res_status <= ST_BAD_FREE;
                res_off    <= free_offset;
                state      <= S_FIN;
              end else begin
                state <= S_FR_RD;
              end
            end
          end
        end
        S_EXACT: begin
          if (pv && rd_free) begin
            res_status <= ST_OK;
            res_off    <= OFF_W'(off_of(pidx, want_d));
            res_lvl    <= LVL_W'(lvl);
            state      <= S_FIN;
          end else if (!pv && cnt >= lim) begin
            cnt   <= '0;
            lim   <= first_of(want_d);
            state <= S_LARGE;
          end else begin
            pv   <= (cnt < lim);
            pidx <= cnt;
            if (cnt < lim) cnt <= cnt + IDX_W'(1);
          end
        end
        S_LARGE: begin
          if (pv && rd_free && (!found || poff < best_off)) begin
            found    <= 1'b1;
            best     <= pidx;
            best_d   <= pdepth;
            best_off <= poff;
          end
          if (!pv && cnt >= lim) begin
            if (found) begin
              cur   <= best;
              cur_d <= best_d;
              state <= S_SPLIT;
            end else begin
              res_status <= ST_NO_SPACE;
              state      <= S_FIN;
            end
          end else begin
            pv   <= (cnt < lim);
            pidx <= cnt;
            if (cnt < lim) cnt <= cnt + IDX_W'(1);
          end
        end
        S_SPLIT: begin
          if (cur_d == want_d) begin
            res_status <= ST_OK;
            res_off    <= OFF_W'(best_off);
            res_lvl    <= LVL_W'(lvl);
            state      <= S_FIN;
          end else begin
            state <= S_SPLIT_R;
          end
        end
        S_SPLIT_R: begin
          cur   <= left_c;
          cur_d <= cur_d + DW'(1);
          state <= S_SPLIT;
        end
        S_FR_RD: state <= S_FR_CHK;
        S_FR_CHK: begin
          if (rdata == ND_ALLOC && base == req_off) begin
            res_status <= ST_OK;
            res_off    <= OFF_W'(req_off);
            res_lvl    <= LVL_W'(DW'(LEVELS - 1) - cur_d);
            state      <= S_MG_RD;
          end else if (rdata != ND_SPLIT || cur_d >= DW'(LEVELS - 1)) begin
            res_status <= ST_BAD_FREE;
            res_off    <= OFF_W'(req_off);
            res_lvl    <= '0;
            state      <= S_FIN;
          end else begin
            if (req_off >= base + half) begin
              base <= base + half;
              cur  <= right_c;
            end else begin
              cur <= left_c;
            end
            cur_d <= cur_d + DW'(1);
            state <= S_FR_RD;
          end
        end
        S_MG_RD:  state <= (cur == '0) ? S_FIN : S_MG_CHK;
        S_MG_CHK: state <= rd_free ? S_MG_W2 : S_FIN;
        S_MG_W2:  state <= S_MG_W3;
        S_MG_W3: begin
          cur   <= parent;
          state <= S_MG_RD;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            block_offset <= res_off;
            size_class   <= res_lvl;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("memory write while idle");

  a_refusal_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_TOO_LARGE || status == ST_NO_SPACE))
      |-> (block_offset == '0 && size_class == '0))
    else $error("refused request carries a block");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result loaded outside finish");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("request accepted without work");

endmodule

// ----- bench/testbench.sv -----
// Testbench for buddy_allocator_core: random and directed alloc/free requests
// checked against an in-bench model of the allocator tree.
// Depends on bal_pkg and buddy_allocator_core.
`timescale 1ns / 100ps

module testbench
  import bal_pkg::*;
();

  localparam int NODES = (1 << DEF_LEVELS) - 1;
  localparam int LIMIT = 6000000;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] offset;
    logic [LVL_W-1:0] level;
  } grant_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic req_type = 0;
  logic [SIZE_W-1:0] req_size = 0;
  logic [OFF_W-1:0] free_offset = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] status;
  logic [OFF_W-1:0] block_offset;
  logic [LVL_W-1:0] size_class;

  node_t tree [NODES];
  grant_t grants_due [$];
  int live_offs [$];
  int errors = 0;
  int cycles = 0;
  int hold_cycles = 0;
  bit steady = 0;

  buddy_allocator_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .req_size(req_size), .free_offset(free_offset),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .block_offset(block_offset), .size_class(size_class)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  function automatic int node_off(int idx, int depth);
    return (idx - ((1 << depth) - 1)) * (DEF_MAX_BLOCK_BYTES >> depth);
  endfunction

  function automatic grant_t model_alloc(int bytes);
    grant_t g;
    int lvl, want, best, bdepth, boff;
    bit found;
    g = '0;
    lvl = 0;
    found = 0;
    best = 0;
    bdepth = 0;
    boff = 0;
    if (bytes > DEF_MAX_BLOCK_BYTES) begin
      g.status = ST_TOO_LARGE;
      return g;
    end
    while (lvl + 1 < DEF_LEVELS && (DEF_MIN_BLOCK_BYTES << lvl) < bytes) lvl++;
    want = DEF_LEVELS - 1 - lvl;
    for (int i = (1 << want) - 1; i < (2 << want) - 1; i++) begin
      if (tree[i] == ND_FREE) begin
        tree[i] = ND_ALLOC;
        g.status = ST_OK;
        g.offset = OFF_W'(node_off(i, want));
        g.level = LVL_W'(lvl);
        return g;
      end
    end
    for (int d = 0; d < want; d++) begin
      for (int i = (1 << d) - 1; i < (2 << d) - 1; i++) begin
        if (tree[i] == ND_FREE && (!found || node_off(i, d) < boff)) begin
          found = 1;
          best = i;
          bdepth = d;
          boff = node_off(i, d);
        end
      end
    end
    if (!found) begin
      g.status = ST_NO_SPACE;
      return g;
    end
    while (bdepth < want) begin
      tree[best] = ND_SPLIT;
      tree[2*best+1] = ND_FREE;
      tree[2*best+2] = ND_FREE;
      best = 2*best + 1;
      bdepth++;
    end
    tree[best] = ND_ALLOC;
    g.status = ST_OK;
    g.offset = OFF_W'(boff);
    g.level = LVL_W'(lvl);
    return g;
  endfunction

  function automatic grant_t model_free(int off);
    grant_t g;
    int i, depth, base, span, sib, par;
    g.status = ST_BAD_FREE;
    g.offset = OFF_W'(off);
    g.level = 0;
    i = 0;
    depth = 0;
    base = 0;
    span = DEF_MAX_BLOCK_BYTES;
    if (off >= DEF_MAX_BLOCK_BYTES) return g;
    forever begin
      if (tree[i] == ND_ALLOC && base == off) break;
      if (tree[i] != ND_SPLIT || depth + 1 >= DEF_LEVELS) return g;
      span = span >> 1;
      if (off >= base + span) begin
        base += span;
        i = 2*i + 2;
      end else begin
        i = 2*i + 1;
      end
      depth++;
    end
    tree[i] = ND_FREE;
    g.status = ST_OK;
    g.level = LVL_W'(DEF_LEVELS - 1 - depth);
    while (i != 0) begin
      sib = (i & 1) ? i + 1 : i - 1;
      par = (i - 1) >> 1;
      if (tree[sib] != ND_FREE) break;
      tree[i] = ND_ABSENT;
      tree[sib] = ND_ABSENT;
      tree[par] = ND_FREE;
      i = par;
    end
    return g;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // one request; model updated at the accepting edge
  task automatic send(bit kind, int bytes, int off);
    grant_t g;
    if (!steady) begin
      while ($urandom_range(0, 3) == 0) begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    in_valid <= 1;
    req_type <= kind;
    req_size <= SIZE_W'(bytes);
    free_offset <= OFF_W'(off);
    do @(posedge clk); while (in_stall);
    g = kind ? model_free(off) : model_alloc(bytes);
    if (!kind && g.status == ST_OK) live_offs.push_back(g.offset);
    if (kind && g.status == ST_OK) begin
      foreach (live_offs[k]) if (live_offs[k] == off) begin
        live_offs.delete(k);
        break;
      end
    end
    grants_due.push_back(g);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  always @(posedge clk) begin
    grant_t w;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (grants_due.size() == 0) begin
        report("unexpected result", status, -1);
      end else begin
        w = grants_due.pop_front();
        if (status != w.status) report("status", status, w.status);
        if (block_offset != w.offset) report("block_offset", block_offset, w.offset);
        if (size_class != w.level) report("size_class", size_class, w.level);
      end
    end
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else if (cycles % 400 < 150) begin
      out_stall <= 0;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_directed();
    send(0, 0, 0);
    send(0, 8, 0);
    send(0, 9, 0);
    send(0, 2049, 0);
    send(0, 16'hFFFF, 0);
    send(1, 0, 0);
    send(1, 0, 8);
    send(1, 0, 4);
    send(1, 0, 11'h7FF);
    send(1, 0, 16);
    send(1, 0, 0);
    send(0, 2048, 0);
    send(0, 1024, 0);
    send(0, 1, 0);
    send(1, 0, 0);
    send(0, 2048, 0);
    send(0, 1, 0);
    send(1, 0, 0);
    send(0, 1024, 0);
    send(0, 1024, 0);
    send(0, 8, 0);
    send(1, 0, 1024);
    send(1, 0, 0);
    send(1, 0, 0);
    drain();
  endtask

  task automatic test_pressure();
    hold_cycles <= 3000;
    steady = 1;
    repeat (20) send(0, $urandom_range(0, 64), 0);
    steady = 0;
    drain();
  endtask

  task automatic test_random(int count);
    int r, n;
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 99);
      if (r < 45) send(0, (1 << $urandom_range(0, 11)) - $urandom_range(0, 1), 0);
      else if (r < 50) send(0, $urandom_range(0, 16'hFFFF), 0);
      else if (r < 85 && live_offs.size() != 0)
        send(1, 0, live_offs[$urandom_range(0, live_offs.size() - 1)]);
      else send(1, 0, $urandom_range(0, 11'h7FF));
      n++;
      if ($urandom_range(0, 15) == 0) steady = !steady;
    end
    steady = 0;
    drain();
  endtask

  initial begin
    foreach (tree[i]) tree[i] = ND_ABSENT;
    tree[0] = ND_FREE;
    repeat (4) @(posedge clk);
    rst <= 0;
    test_directed();
    test_pressure();
    test_random(1900);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/bal_pkg.sv
design/bal_mem.sv
design/buddy_allocator_core.sv
bench/testbench.sv
